/* rtl/cipadv_pkg.sv */
// Shared constants, types and helper functions for the CIP advection cell update block.
package cipadv_pkg;

  // Number format of values, slopes and velocity.
  localparam int VALUE_BITS    = 32;
  localparam int FRACTION_BITS = 24;
  // Fraction bits of the dt/dx register.
  localparam int COURANT_BITS  = 24;

  // Internal width for coefficients and partial sums, with headroom for growth.
  localparam int INT_BITS  = VALUE_BITS + 8;
  // Courant number, unsigned, at most one.
  localparam int S_BITS    = FRACTION_BITS + 1;
  // Raw Courant product before the clip.
  localparam int CPROD_BITS = VALUE_BITS + COURANT_BITS;
  // Width used to compare the raw Courant number against one.
  localparam int CMP_BITS  = (VALUE_BITS > S_BITS) ? VALUE_BITS : S_BITS;
  // Signed product of an internal value and the Courant number.
  localparam int PROD_BITS = INT_BITS + S_BITS + 1;

  // Stream widths.
  localparam int NUM_IN_FIELDS = 7;
  localparam int IN_BITS       = ((NUM_IN_FIELDS * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS      = ((2 * VALUE_BITS + 7) / 8) * 8;
  localparam int USER_BITS     = 2;

  // Bit positions in the output tuser.
  localparam int USER_CLIPPED   = 0;
  localparam int USER_SATURATED = 1;

  // Field slots in the input tdata, lowest first.
  localparam int FLD_VALUE_LEFT   = 0;
  localparam int FLD_VALUE_CENTER = 1;
  localparam int FLD_VALUE_RIGHT  = 2;
  localparam int FLD_SLOPE_LEFT   = 3;
  localparam int FLD_SLOPE_CENTER = 4;
  localparam int FLD_SLOPE_RIGHT  = 5;
  localparam int FLD_VELOCITY     = 6;

  // Pipeline depth.
  localparam int NUM_STAGES = 9;

  // Per-stage load enables from the pipeline control.
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctrl_t;

  // Coefficients and Courant number handed from the front end to the evaluator.
  typedef struct packed {
    logic signed [INT_BITS-1:0]   coef_a;
    logic signed [INT_BITS-1:0]   coef_b;
    logic signed [INT_BITS-1:0]   slope_c;
    logic signed [VALUE_BITS-1:0] value_c;
    logic [S_BITS-1:0]            courant;
    logic                         from_lower;
    logic                         clipped;
  } coef_t;

  // floor(x * s / 2^FRACTION_BITS) from the exact signed product.
  function automatic logic signed [INT_BITS-1:0] scale_floor(
    input logic signed [PROD_BITS-1:0] prod
  );
    return prod[FRACTION_BITS +: INT_BITS];
  endfunction

endpackage

/* rtl/cipadv_ctrl.sv */
// Valid chain and per-stage load enables for the datapath pipeline.
module cipadv_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output cipadv_pkg::pipe_ctrl_t  ctrl_o
);

  logic [cipadv_pkg::NUM_STAGES-1:0] valid_q, valid_d;
  logic [cipadv_pkg::NUM_STAGES-1:0] load;

  // A stage loads when it is empty or its content moves on; bubbles collapse.
  always_comb begin
    load[cipadv_pkg::NUM_STAGES-1] = !valid_q[cipadv_pkg::NUM_STAGES-1] || out_ready_i;
    for (int k = cipadv_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  // Valid bits travel with the data.
  always_comb begin
    valid_d = valid_q;
    if (load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < cipadv_pkg::NUM_STAGES; k++) begin
      if (load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[cipadv_pkg::NUM_STAGES-1];
  assign ctrl_o.load = load;

endmodule

/* rtl/cipadv_coef.sv */
// Front end: upwind selection, cubic coefficients and the clipped Courant number.
module cipadv_coef (
  input  logic                                  clk_i,
  input  logic [cipadv_pkg::IN_BITS-1:0]        in_data_i,
  input  logic [cipadv_pkg::COURANT_BITS-1:0]   courant_factor_i,
  input  cipadv_pkg::pipe_ctrl_t                ctrl_i,
  output cipadv_pkg::coef_t                     coef_o
);

  localparam int VB = cipadv_pkg::VALUE_BITS;
  localparam int IB = cipadv_pkg::INT_BITS;

  // Field unpacking.
  logic signed [VB-1:0] fl, fc, fr, gl, gc, gr, vel;
  assign fl  = in_data_i[cipadv_pkg::FLD_VALUE_LEFT   * VB +: VB];
  assign fc  = in_data_i[cipadv_pkg::FLD_VALUE_CENTER * VB +: VB];
  assign fr  = in_data_i[cipadv_pkg::FLD_VALUE_RIGHT  * VB +: VB];
  assign gl  = in_data_i[cipadv_pkg::FLD_SLOPE_LEFT   * VB +: VB];
  assign gc  = in_data_i[cipadv_pkg::FLD_SLOPE_CENTER * VB +: VB];
  assign gr  = in_data_i[cipadv_pkg::FLD_SLOPE_RIGHT  * VB +: VB];
  assign vel = in_data_i[cipadv_pkg::FLD_VELOCITY     * VB +: VB];

  // Stage 1: pick the upwind side, orient slopes toward it, velocity magnitude.
  logic                 low_1_d, low_1_q;
  logic [VB-1:0]        mag_1_d, mag_1_q;
  logic signed [VB:0]   diff_1_d, diff_1_q;
  logic signed [VB:0]   gcp_1_d, gcp_1_q;
  logic signed [VB:0]   gup_1_d, gup_1_q;
  logic signed [VB-1:0] fc_1_q;

  always_comb begin
    low_1_d = !vel[VB-1];
    mag_1_d = low_1_d ? vel : (VB'(0) - vel);
    if (low_1_d) begin
      diff_1_d = (VB+1)'(fc) - (VB+1)'(fl);
      gcp_1_d  = (VB+1)'(0) - (VB+1)'(gc);
      gup_1_d  = (VB+1)'(0) - (VB+1)'(gl);
    end else begin
      diff_1_d = (VB+1)'(fc) - (VB+1)'(fr);
      gcp_1_d  = (VB+1)'(gc);
      gup_1_d  = (VB+1)'(gr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[0]) begin
      low_1_q  <= low_1_d;
      mag_1_q  <= mag_1_d;
      diff_1_q <= diff_1_d;
      gcp_1_q  <= gcp_1_d;
      gup_1_q  <= gup_1_d;
      fc_1_q   <= fc;
    end
  end

  // Stage 2: Courant product and the two cubic coefficients.
  logic [cipadv_pkg::CPROD_BITS-1:0] cprod_2_d, cprod_2_q;
  logic signed [IB-1:0] a_2_d, a_2_q, b_2_d, b_2_q;
  logic signed [IB-1:0] d_ext, gcp_ext, gup_ext;
  logic signed [IB-1:0] gcp_2_q;
  logic signed [VB-1:0] fc_2_q;
  logic                 low_2_q;

  always_comb begin
    d_ext     = IB'(diff_1_q);
    gcp_ext   = IB'(gcp_1_q);
    gup_ext   = IB'(gup_1_q);
    cprod_2_d = cipadv_pkg::CPROD_BITS'(mag_1_q)
              * cipadv_pkg::CPROD_BITS'(courant_factor_i);
    // A = G'c + G'u - 2*(fu - fc), B = 3*(fu - fc) - 2*G'c - G'u
    a_2_d = gcp_ext + gup_ext + (d_ext <<< 1);
    b_2_d = IB'(0) - (d_ext + (d_ext <<< 1) + (gcp_ext <<< 1) + gup_ext);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[1]) begin
      cprod_2_q <= cprod_2_d;
      a_2_q     <= a_2_d;
      b_2_q     <= b_2_d;
      gcp_2_q   <= gcp_ext;
      fc_2_q    <= fc_1_q;
      low_2_q   <= low_1_q;
    end
  end

  // Stage 3: scale the Courant number and clip it to one.
  localparam logic [cipadv_pkg::CMP_BITS-1:0] ONE_CMP =
    cipadv_pkg::CMP_BITS'(1) << cipadv_pkg::FRACTION_BITS;

  logic [VB-1:0]                     s_raw;
  logic                              clip_3_d;
  logic [cipadv_pkg::S_BITS-1:0]     s_3_d;
  cipadv_pkg::coef_t                 coef_q;

  always_comb begin
    s_raw    = cprod_2_q[cipadv_pkg::COURANT_BITS +: VB];
    clip_3_d = cipadv_pkg::CMP_BITS'(s_raw) > ONE_CMP;
    s_3_d    = clip_3_d ? cipadv_pkg::S_BITS'(ONE_CMP) : cipadv_pkg::S_BITS'(s_raw);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[2]) begin
      coef_q.coef_a     <= a_2_q;
      coef_q.coef_b     <= b_2_q;
      coef_q.slope_c    <= gcp_2_q;
      coef_q.value_c    <= fc_2_q;
      coef_q.courant    <= s_3_d;
      coef_q.from_lower <= low_2_q;
      coef_q.clipped    <= clip_3_d;
    end
  end

  assign coef_o = coef_q;

endmodule

/* rtl/cipadv_eval.sv */
// Back end: polynomial evaluation in the Courant number, saturation and result register.
module cipadv_eval (
  input  logic                                clk_i,
  input  cipadv_pkg::coef_t                   coef_i,
  input  cipadv_pkg::pipe_ctrl_t              ctrl_i,
  output logic [cipadv_pkg::OUT_BITS-1:0]     out_data_o,
  output logic [cipadv_pkg::USER_BITS-1:0]    out_user_o
);

  localparam int VB = cipadv_pkg::VALUE_BITS;
  localparam int IB = cipadv_pkg::INT_BITS;
  localparam int PB = cipadv_pkg::PROD_BITS;
  localparam int SB = cipadv_pkg::S_BITS;

  // Stage 4: s*A.
  logic signed [SB:0]   s_sgn;
  logic signed [PB-1:0] pa_4_d, pa_4_q;
  logic signed [IB-1:0] b_4_q, gcp_4_q;
  logic signed [VB-1:0] fc_4_q;
  logic [SB-1:0]        s_4_q;
  logic                 low_4_q, clip_4_q;

  assign s_sgn  = {1'b0, coef_i.courant};
  assign pa_4_d = coef_i.coef_a * s_sgn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[3]) begin
      pa_4_q   <= pa_4_d;
      b_4_q    <= coef_i.coef_b;
      gcp_4_q  <= coef_i.slope_c;
      fc_4_q   <= coef_i.value_c;
      s_4_q    <= coef_i.courant;
      low_4_q  <= coef_i.from_lower;
      clip_4_q <= coef_i.clipped;
    end
  end

  // Stage 5: B + sA for the value, 2B + 3sA for the slope.
  logic signed [IB-1:0] sa_5, t1_5_d, t2_5_d, t1_5_q, t2_5_q, gcp_5_q;
  logic signed [VB-1:0] fc_5_q;
  logic [SB-1:0]        s_5_q;
  logic                 low_5_q, clip_5_q;

  always_comb begin
    sa_5   = cipadv_pkg::scale_floor(pa_4_q);
    t1_5_d = b_4_q + sa_5;
    t2_5_d = (b_4_q <<< 1) + (sa_5 <<< 1) + sa_5;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[4]) begin
      t1_5_q   <= t1_5_d;
      t2_5_q   <= t2_5_d;
      gcp_5_q  <= gcp_4_q;
      fc_5_q   <= fc_4_q;
      s_5_q    <= s_4_q;
      low_5_q  <= low_4_q;
      clip_5_q <= clip_4_q;
    end
  end

  // Stage 6: both products by s.
  logic signed [SB:0]   s5_sgn;
  logic signed [PB-1:0] p1_6_d, p2_6_d, p1_6_q, p2_6_q;
  logic signed [IB-1:0] gcp_6_q;
  logic signed [VB-1:0] fc_6_q;
  logic [SB-1:0]        s_6_q;
  logic                 low_6_q, clip_6_q;

  assign s5_sgn = {1'b0, s_5_q};
  assign p1_6_d = t1_5_q * s5_sgn;
  assign p2_6_d = t2_5_q * s5_sgn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[5]) begin
      p1_6_q   <= p1_6_d;
      p2_6_q   <= p2_6_d;
      gcp_6_q  <= gcp_5_q;
      fc_6_q   <= fc_5_q;
      s_6_q    <= s_5_q;
      low_6_q  <= low_5_q;
      clip_6_q <= clip_5_q;
    end
  end

  // Stage 7: add the local slope; turn the slope back to grid direction.
  logic signed [IB-1:0] u_7_d, u_7_q, g_7, ng_7_d, ng_7_q;
  logic signed [VB-1:0] fc_7_q;
  logic [SB-1:0]        s_7_q;
  logic                 clip_7_q;

  always_comb begin
    u_7_d  = gcp_6_q + cipadv_pkg::scale_floor(p1_6_q);
    g_7    = gcp_6_q + cipadv_pkg::scale_floor(p2_6_q);
    ng_7_d = low_6_q ? (IB'(0) - g_7) : g_7;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[6]) begin
      u_7_q    <= u_7_d;
      ng_7_q   <= ng_7_d;
      fc_7_q   <= fc_6_q;
      s_7_q    <= s_6_q;
      clip_7_q <= clip_6_q;
    end
  end

  // Stage 8: last product by s for the value.
  logic signed [SB:0]   s7_sgn;
  logic signed [PB-1:0] p3_8_d, p3_8_q;
  logic signed [IB-1:0] ng_8_q;
  logic signed [VB-1:0] fc_8_q;
  logic                 clip_8_q;

  assign s7_sgn = {1'b0, s_7_q};
  assign p3_8_d = u_7_q * s7_sgn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[7]) begin
      p3_8_q   <= p3_8_d;
      ng_8_q   <= ng_7_q;
      fc_8_q   <= fc_7_q;
      clip_8_q <= clip_7_q;
    end
  end

  // Stage 9: final sum, saturation to the value range, result register.
  localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
  localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

  logic signed [IB-1:0] nv_9;
  logic                 nv_ovf, ng_ovf;
  logic signed [VB-1:0] nv_sat, ng_sat;
  logic [cipadv_pkg::OUT_BITS-1:0]  data_q, data_d;
  logic [cipadv_pkg::USER_BITS-1:0] user_q, user_d;

  always_comb begin
    nv_9   = IB'(fc_8_q) + cipadv_pkg::scale_floor(p3_8_q);
    // In range when all bits above the value's sign bit match it.
    nv_ovf = !((&nv_9[IB-1:VB-1]) || !(|nv_9[IB-1:VB-1]));
    ng_ovf = !((&ng_8_q[IB-1:VB-1]) || !(|ng_8_q[IB-1:VB-1]));
    nv_sat = nv_ovf ? (nv_9[IB-1] ? VMIN : VMAX) : nv_9[VB-1:0];
    ng_sat = ng_ovf ? (ng_8_q[IB-1] ? VMIN : VMAX) : ng_8_q[VB-1:0];
    data_d = cipadv_pkg::OUT_BITS'({ng_sat, nv_sat});
    user_d = '0;
    user_d[cipadv_pkg::USER_CLIPPED]   = clip_8_q;
    user_d[cipadv_pkg::USER_SATURATED] = nv_ovf || ng_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[8]) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign out_data_o = data_q;
  assign out_user_o = user_q;

endmodule

/* rtl/cip_advection_cell_update.sv */
// Top level of the CIP advection cell update block: ports, config register, pipeline.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: the three values, the three scaled slopes, velocity
//  m_axis    out        tdata: new value, new slope; tuser: clip and saturation flags
//  cfg       in         data: dt/dx (Courant factor), unsigned Q0.24
//
// Nine register stages; a beat enters every cycle when the output side does not
// stall. The depth is set by the chain of three dependent products by the Courant
// number, one multiplier stage each. Reset clears the valid bits and the Courant
// factor to zero. A stall on m_axis holds the last stage; earlier stages keep
// moving into empty slots, so s_axis stays ready until the pipeline is full.
module cip_advection_cell_update (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // value_left, value_center, value_right, slope_left, slope_center,
  // slope_right, velocity (lowest first)
  input  logic [cipadv_pkg::IN_BITS-1:0]        s_axis_tdata_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // new_value, new_slope (lowest first)
  output logic [cipadv_pkg::OUT_BITS-1:0]       m_axis_tdata_o,
  // courant_clipped, result_saturated (lowest first)
  output logic [cipadv_pkg::USER_BITS-1:0]      m_axis_tuser_o,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  input  logic [cipadv_pkg::COURANT_BITS-1:0]   cfg_data_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o
);

  // Courant factor register, written by a cfg beat.
  logic [cipadv_pkg::COURANT_BITS-1:0] courant_factor_q, courant_factor_d;

  assign cfg_ready_o      = 1'b1;
  assign courant_factor_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : courant_factor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      courant_factor_q <= '0;
    end else begin
      courant_factor_q <= courant_factor_d;
    end
  end

  // Pipeline control.
  cipadv_pkg::pipe_ctrl_t ctrl;

  cipadv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .ctrl_o      (ctrl)
  );

  // Coefficients and Courant number.
  cipadv_pkg::coef_t coef;

  cipadv_coef u_coef (
    .clk_i            (clk_i),
    .in_data_i        (s_axis_tdata_i),
    .courant_factor_i (courant_factor_q),
    .ctrl_i           (ctrl),
    .coef_o           (coef)
  );

  // Polynomial evaluation and result register.
  cipadv_eval u_eval (
    .clk_i      (clk_i),
    .coef_i     (coef),
    .ctrl_i     (ctrl),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o)
  );

endmodule
